// ===== sv/dwlm_pkg.sv =====
// ----------------------------------------------------------------------------
// dwlm_pkg
// Shared types and constants of the dual-window layer mask.
// ----------------------------------------------------------------------------
package dwlm_pkg;

	localparam int XW      = 8;
	localparam int LAYER_W = 3;
	localparam int SEL_W   = 4;
	localparam int CODE_W  = 2;
	localparam int CODES_W = 12;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;

	localparam int SEL_INV1 = 0;
	localparam int SEL_EN1  = 1;
	localparam int SEL_INV2 = 2;
	localparam int SEL_EN2  = 3;

	typedef enum logic [2:0] {
		REG_W1_LEFT   = 3'd0,
		REG_W1_RIGHT  = 3'd1,
		REG_W2_LEFT   = 3'd2,
		REG_W2_RIGHT  = 3'd3,
		REG_BG_A_SEL  = 3'd4,
		REG_BG_B_SEL  = 3'd5,
		REG_SPR_COL   = 3'd6,
		REG_COMBINE   = 3'd7
	} reg_idx_t;

	typedef enum logic [CODE_W-1:0] {
		COMB_OR   = 2'd0,
		COMB_AND  = 2'd1,
		COMB_XOR  = 2'd2,
		COMB_XNOR = 2'd3
	} comb_t;

	typedef enum logic [LAYER_W-1:0] {
		LAYER_BG0    = 3'd0,
		LAYER_BG1    = 3'd1,
		LAYER_BG2    = 3'd2,
		LAYER_BG3    = 3'd3,
		LAYER_SPRITE = 3'd4,
		LAYER_COLOUR = 3'd5,
		LAYER_BAD6   = 3'd6,
		LAYER_BAD7   = 3'd7
	} layer_t;

	typedef struct packed {
		logic [XW-1:0]      w1_left;
		logic [XW-1:0]      w1_right;
		logic [XW-1:0]      w2_left;
		logic [XW-1:0]      w2_right;
		logic [7:0]         bg_a_sel;
		logic [7:0]         bg_b_sel;
		logic [7:0]         spr_col_sel;
		logic [CODES_W-1:0] combine;
	} cfg_t;

endpackage

// ===== sv/dual_window_layer_mask.sv =====
// ----------------------------------------------------------------------------
// dual_window_layer_mask
// Per-column, per-layer window mask from two horizontal windows.
//
//   channel   dir   handshake          payload
//   s_*       in    s_tvalid/s_tready  s_tuser[2:0] layer, s_tdata[7:0] pixel_x
//   m_*       out   m_tvalid/m_tready  m_tdata[0] masked, [7:1] zero
//   apb       in    psel/penable       paddr[4:2] register, pwdata/prdata
//
// One request per cycle sustained while m_tready is high; a result is
// registered through the compare, invert/enable and combine stages in turn
// before it is presented on m_*.
// Reset clears the stage valid bits and all configuration registers.
// A stall on m_tready holds the full stages while empty stages close up;
// s_tready drops only when all three stages are full and the output is not taken.
// ----------------------------------------------------------------------------
module dual_window_layer_mask (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [dwlm_pkg::ADDR_W-1:0]  paddr,
	input  logic [dwlm_pkg::DATA_W-1:0]  pwdata,
	output logic [dwlm_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,  // [7:0] pixel_x
	input  logic [dwlm_pkg::LAYER_W-1:0] s_tuser,  // [2:0] layer
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [7:0]                   m_tdata   // [0] masked, [7:1] zero
);

	dwlm_pkg::cfg_t cfg;
	logic           masked;

	dwlm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dwlm_pipe u_pipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_layer   (s_tuser),
		.in_x       (s_tdata[dwlm_pkg::XW-1:0]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_masked (masked)
	);

	assign m_tdata = {7'd0, masked};

endmodule

// ===== sv/dwlm_cfg.sv =====
// ----------------------------------------------------------------------------
// dwlm_cfg
// Configuration register file behind a simple APB slave.
// ----------------------------------------------------------------------------
module dwlm_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dwlm_pkg::ADDR_W-1:0] paddr,
	input  logic [dwlm_pkg::DATA_W-1:0] pwdata,
	output logic [dwlm_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output dwlm_pkg::cfg_t              cfg
);

	dwlm_pkg::cfg_t   cfg_q;
	dwlm_pkg::reg_idx_t idx;
	logic             wr_en;

	assign idx    = dwlm_pkg::reg_idx_t'(paddr[dwlm_pkg::ADDR_W-1:2]);
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (idx)
				dwlm_pkg::REG_W1_LEFT:  cfg_q.w1_left     <= pwdata[7:0];
				dwlm_pkg::REG_W1_RIGHT: cfg_q.w1_right    <= pwdata[7:0];
				dwlm_pkg::REG_W2_LEFT:  cfg_q.w2_left     <= pwdata[7:0];
				dwlm_pkg::REG_W2_RIGHT: cfg_q.w2_right    <= pwdata[7:0];
				dwlm_pkg::REG_BG_A_SEL: cfg_q.bg_a_sel    <= pwdata[7:0];
				dwlm_pkg::REG_BG_B_SEL: cfg_q.bg_b_sel    <= pwdata[7:0];
				dwlm_pkg::REG_SPR_COL:  cfg_q.spr_col_sel <= pwdata[7:0];
				dwlm_pkg::REG_COMBINE:  cfg_q.combine     <= pwdata[dwlm_pkg::CODES_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			dwlm_pkg::REG_W1_LEFT:  prdata[7:0] = cfg_q.w1_left;
			dwlm_pkg::REG_W1_RIGHT: prdata[7:0] = cfg_q.w1_right;
			dwlm_pkg::REG_W2_LEFT:  prdata[7:0] = cfg_q.w2_left;
			dwlm_pkg::REG_W2_RIGHT: prdata[7:0] = cfg_q.w2_right;
			dwlm_pkg::REG_BG_A_SEL: prdata[7:0] = cfg_q.bg_a_sel;
			dwlm_pkg::REG_BG_B_SEL: prdata[7:0] = cfg_q.bg_b_sel;
			dwlm_pkg::REG_SPR_COL:  prdata[7:0] = cfg_q.spr_col_sel;
			dwlm_pkg::REG_COMBINE:  prdata[dwlm_pkg::CODES_W-1:0] = cfg_q.combine;
			default:                prdata = '0;
		endcase
	end

endmodule

// ===== sv/dwlm_pipe.sv =====
// ----------------------------------------------------------------------------
// dwlm_pipe
// Three-stage mask pipeline: window compare, invert/enable, combine.
// ----------------------------------------------------------------------------
module dwlm_pipe (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dwlm_pkg::cfg_t               cfg,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [dwlm_pkg::LAYER_W-1:0] in_layer,
	input  logic [dwlm_pkg::XW-1:0]      in_x,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         out_masked
);

	logic adv1, adv2, adv3;
	logic v_s1, v_s2, v_s3;

	logic                        cov1_s1, cov2_s1, ok_s1;
	logic [dwlm_pkg::SEL_W-1:0]  sel_s1;
	logic [dwlm_pkg::CODE_W-1:0] code_s1;

	logic                        w1_s2, w2_s2, e1_s2, e2_s2;
	logic [dwlm_pkg::CODE_W-1:0] code_s2;

	logic masked_s3;

	logic                        cov1_d, cov2_d, ok_d;
	logic [7:0]                  pair_d;
	logic [dwlm_pkg::SEL_W-1:0]  sel_d;
	logic [dwlm_pkg::CODE_W-1:0] code_d;
	logic                        res_d;

	assign adv3     = !v_s3 | out_ready;
	assign adv2     = !v_s2 | adv3;
	assign adv1     = !v_s1 | adv2;
	assign in_ready = adv1;

	assign out_valid  = v_s3;
	assign out_masked = masked_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	// stage 1: window compares, select and code lookup
	always_comb begin
		cov1_d = (cfg.w1_left <= cfg.w1_right) && (in_x >= cfg.w1_left)
			&& (in_x <= cfg.w1_right);
		cov2_d = (cfg.w2_left <= cfg.w2_right) && (in_x >= cfg.w2_left)
			&& (in_x <= cfg.w2_right);
		case (in_layer[2:1])
			2'd0:    pair_d = cfg.bg_a_sel;
			2'd1:    pair_d = cfg.bg_b_sel;
			default: pair_d = cfg.spr_col_sel;
		endcase
		sel_d = in_layer[0] ? pair_d[7:4] : pair_d[3:0];
		ok_d  = 1'b1;
		case (dwlm_pkg::layer_t'(in_layer))
			dwlm_pkg::LAYER_BG0:    code_d = cfg.combine[1:0];
			dwlm_pkg::LAYER_BG1:    code_d = cfg.combine[3:2];
			dwlm_pkg::LAYER_BG2:    code_d = cfg.combine[5:4];
			dwlm_pkg::LAYER_BG3:    code_d = cfg.combine[7:6];
			dwlm_pkg::LAYER_SPRITE: code_d = cfg.combine[9:8];
			dwlm_pkg::LAYER_COLOUR: code_d = cfg.combine[11:10];
			default: begin
				code_d = '0;
				ok_d   = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			cov1_s1 <= cov1_d;
			cov2_s1 <= cov2_d;
			sel_s1  <= sel_d;
			code_s1 <= code_d;
			ok_s1   <= ok_d;
		end
	end

	// stage 2: apply invert and enable
	always_ff @(posedge clk) begin
		if (adv2) begin
			w1_s2   <= cov1_s1 ^ sel_s1[dwlm_pkg::SEL_INV1];
			w2_s2   <= cov2_s1 ^ sel_s1[dwlm_pkg::SEL_INV2];
			e1_s2   <= ok_s1 & sel_s1[dwlm_pkg::SEL_EN1];
			e2_s2   <= ok_s1 & sel_s1[dwlm_pkg::SEL_EN2];
			code_s2 <= code_s1;
		end
	end

	// stage 3: combine
	always_comb begin
		if (e1_s2 && e2_s2) begin
			case (dwlm_pkg::comb_t'(code_s2))
				dwlm_pkg::COMB_OR:   res_d = w1_s2 | w2_s2;
				dwlm_pkg::COMB_AND:  res_d = w1_s2 & w2_s2;
				dwlm_pkg::COMB_XOR:  res_d = w1_s2 ^ w2_s2;
				dwlm_pkg::COMB_XNOR: res_d = ~(w1_s2 ^ w2_s2);
				default:             res_d = 1'b0;
			endcase
		end else if (e1_s2) begin
			res_d = w1_s2;
		end else if (e2_s2) begin
			res_d = w2_s2;
		end else begin
			res_d = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) masked_s3 <= res_d;
	end

endmodule
